// File: rtl/core/modexp_pkg.sv
// package for the modular exponentiation block: constants and controller types
package modexp_pkg;
    localparam int WORD_BITS_DEF = 32;

    typedef enum logic [3:0] {
        ST_IDLE, ST_RED_STEP, ST_CHECK, ST_MUL_START, ST_MUL_STEP,
        ST_SQR_START, ST_SQR_STEP, ST_SHIFT, ST_OUT
    } modexp_state_t;

    typedef struct packed {
        logic load;       // capture operands, begin base reduction
        logic red_step;   // one reduction bit
        logic mul_start;  // begin acc * pw
        logic sqr_start;  // begin pw * pw
        logic mm_step;    // one modular multiply bit
        logic mul_done;   // write product to acc
        logic sqr_done;   // write product to pw
        logic shift;      // drop exponent bit
    } modexp_cmd_t;

    typedef struct packed {
        logic last_bit;   // step counter at final bit
        logic exp_zero;   // exponent exhausted
        logic exp_lsb;    // current exponent bit
    } modexp_sts_t;
endpackage

// File: rtl/core/modexp_ctrl.sv
// controller state machine for square-and-multiply sequencing
module modexp_ctrl import modexp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    input  logic        mod_zero,
    input  modexp_sts_t sts,
    output modexp_cmd_t cmd
);
    modexp_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:      if (in_valid) state_next = mod_zero ? ST_OUT : ST_RED_STEP;
            ST_RED_STEP:  if (sts.last_bit) state_next = ST_CHECK;
            ST_CHECK: begin
                if (sts.exp_zero) state_next = ST_OUT;
                else if (sts.exp_lsb) state_next = ST_MUL_START;
                else state_next = ST_SQR_START;
            end
            ST_MUL_START: state_next = ST_MUL_STEP;
            ST_MUL_STEP:  if (sts.last_bit) state_next = ST_SQR_START;
            ST_SQR_START: state_next = ST_SQR_STEP;
            ST_SQR_STEP:  if (sts.last_bit) state_next = ST_SHIFT;
            ST_SHIFT:     state_next = ST_CHECK;
            ST_OUT:       if (out_ready) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd       = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready      = 1'b1;
                cmd.load      = in_valid;
            end
            ST_RED_STEP:  cmd.red_step = 1'b1;
            ST_MUL_START: cmd.mul_start = 1'b1;
            ST_MUL_STEP: begin
                cmd.mm_step  = 1'b1;
                cmd.mul_done = sts.last_bit;
            end
            ST_SQR_START: cmd.sqr_start = 1'b1;
            ST_SQR_STEP: begin
                cmd.mm_step  = 1'b1;
                cmd.sqr_done = sts.last_bit;
            end
            ST_SHIFT:     cmd.shift = 1'b1;
            ST_OUT:       out_valid = 1'b1;
            default:      cmd = '0;
        endcase
    end
endmodule

// File: rtl/core/modexp_dp.sv
// datapath: operand registers, bit-serial reduction and modular multiply
module modexp_dp import modexp_pkg::*; #(
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic                 aclk,
    input  logic [WORD_BITS-1:0] base,
    input  logic [WORD_BITS-1:0] exponent,
    input  logic [WORD_BITS-1:0] modulus,
    input  modexp_cmd_t          cmd,
    output modexp_sts_t          sts,
    output logic                 mod_zero,
    output logic [WORD_BITS-1:0] result,
    output logic                 error
);
    localparam int CW = $clog2(WORD_BITS);

    logic [WORD_BITS-1:0] mod_reg, exp_reg, acc_reg, pw_reg, r_reg, b_reg, a_reg;
    logic [CW-1:0]        cnt_reg;
    logic                 err_reg;
    logic [WORD_BITS:0]   dbl, dsum, rsum, red_sh;
    logic [WORD_BITS-1:0] dmod, r_after;

    assign mod_zero = (modulus == '0);

    // r = 2r mod m, then optionally + a mod m (r, a < m)
    always_comb begin
        dbl     = {r_reg, 1'b0};
        dmod    = (dbl >= {1'b0, mod_reg}) ? WORD_BITS'(dbl - {1'b0, mod_reg})
                                           : dbl[WORD_BITS-1:0];
        dsum    = {1'b0, dmod} + {1'b0, a_reg};
        r_after = b_reg[WORD_BITS-1]
                ? ((dsum >= {1'b0, mod_reg}) ? WORD_BITS'(dsum - {1'b0, mod_reg})
                                             : dsum[WORD_BITS-1:0])
                : dmod;
        // restoring remainder step for base reduction, base bits in b_reg
        red_sh  = {r_reg, b_reg[WORD_BITS-1]};
        rsum    = (red_sh >= {1'b0, mod_reg}) ? red_sh - {1'b0, mod_reg} : red_sh;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mod_reg <= modulus;
            exp_reg <= exponent;
            acc_reg <= WORD_BITS'(1);
            err_reg <= mod_zero;
            r_reg   <= '0;
            b_reg   <= base;
            cnt_reg <= '0;
        end
        if (cmd.red_step) begin
            r_reg   <= rsum[WORD_BITS-1:0];
            b_reg   <= {b_reg[WORD_BITS-2:0], 1'b0};
            cnt_reg <= cnt_reg + CW'(1);
            if (sts.last_bit) pw_reg <= rsum[WORD_BITS-1:0];
        end
        if (cmd.mul_start || cmd.sqr_start) begin
            r_reg   <= '0;
            a_reg   <= pw_reg;
            b_reg   <= cmd.mul_start ? acc_reg : pw_reg;
            cnt_reg <= '0;
        end
        if (cmd.mm_step) begin
            r_reg   <= r_after;
            b_reg   <= {b_reg[WORD_BITS-2:0], 1'b0};
            cnt_reg <= cnt_reg + CW'(1);
        end
        if (cmd.mul_done) acc_reg <= r_after;
        if (cmd.sqr_done) pw_reg  <= r_after;
        if (cmd.shift)    exp_reg <= exp_reg >> 1;
    end

    assign sts.last_bit = (cnt_reg == CW'(WORD_BITS - 1));
    assign sts.exp_zero = (exp_reg == '0);
    assign sts.exp_lsb  = exp_reg[0];
    assign error  = err_reg;
    assign result = err_reg ? '0 : acc_reg;
endmodule

// File: rtl/core/modular_exponentiation.sv
// top level: modular exponentiation with stream-style handshake
//
// channel | direction | tdata fields (low bit up)
// s_      | in        | base[W-1:0], exponent, modulus (3W bits, byte padded)
// m_      | out       | result[W-1:0]; tuser = error
//
// sequence: accept, W steps of base reduction, then per exponent bit a check,
//   a multiply if the bit is set and a square (each a start state plus W steps
//   of the bit-serial modular multiplier) and a shift; a final check and the
//   output state
// a zero modulus goes straight from idle to the output state
// reset: aresetn synchronous active low, returns to idle
// one item at a time; result holds until m_tready
module modular_exponentiation import modexp_pkg::*; #(
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // base, exponent, modulus from bit 0 up
    input  logic [((3*WORD_BITS+7)/8)*8-1:0]    s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // result
    output logic [((WORD_BITS+7)/8)*8-1:0]      m_tdata,
    // error
    output logic                                m_tuser
);
    localparam int OW = ((WORD_BITS + 7) / 8) * 8;

    modexp_cmd_t          cmd;
    modexp_sts_t          sts;
    logic                 mod_zero;
    logic [WORD_BITS-1:0] result;

    // controller sequences reduction, multiply and square passes
    modexp_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .mod_zero  (mod_zero),
        .sts       (sts),
        .cmd       (cmd)
    );

    // datapath holds operands and the shift-add modular multiplier
    modexp_dp #(.WORD_BITS(WORD_BITS)) u_dp (
        .aclk     (aclk),
        .base     (s_tdata[WORD_BITS-1:0]),
        .exponent (s_tdata[2*WORD_BITS-1:WORD_BITS]),
        .modulus  (s_tdata[3*WORD_BITS-1:2*WORD_BITS]),
        .cmd      (cmd),
        .sts      (sts),
        .mod_zero (mod_zero),
        .result   (result),
        .error    (m_tuser)
    );

    assign m_tdata = OW'(result);
endmodule

// File: tb/modular_exponentiation_tb.sv
// testbench for the modular exponentiation block: random and corner items vs a predictor
module modular_exponentiation_tb;
    import modexp_pkg::*;

    localparam int W = WORD_BITS_DEF;
    localparam int IN_BYTES_W = ((3*W+7)/8)*8;
    localparam int OUT_BYTES_W = ((W+7)/8)*8;
    // no progress for this many cycles means a hang
    localparam int STALL_LIMIT = 40000;

    typedef struct packed {
        logic [W-1:0] modulus;
        logic [W-1:0] exponent;
        logic [W-1:0] base;
    } operands_t;

    typedef struct packed {
        logic [W-1:0] result;
        logic         error;
    } power_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_BYTES_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_BYTES_W-1:0] m_tdata;
    logic m_tuser;

    operands_t pending_items[$];
    power_t    expected_powers[$];
    int        errors = 0;
    int        quiet_cycles = 0;
    bit        stimulus_done = 1'b0;
    bit        hold_sender = 1'b0;
    int        send_gap = 0;
    int        recv_gap = 0;

    modular_exponentiation #(.WORD_BITS(W)) u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // exact (a * b) mod m by double-width arithmetic
    function automatic logic [W-1:0] mulmod(logic [W-1:0] a, logic [W-1:0] b, logic [W-1:0] m);
        logic [2*W-1:0] p;
        p = a * b;
        return W'(p % m);
    endfunction

    function automatic power_t predict_power(operands_t op);
        power_t r;
        logic [W-1:0] acc;
        logic [W-1:0] pw;
        logic [W-1:0] e;
        r = '0;
        if (op.modulus == '0) begin
            r.error = 1'b1;
            return r;
        end
        // no reduction at all for a zero exponent, so modulus 1 still gives 1
        acc = W'(1);
        pw = op.base % op.modulus;
        e = op.exponent;
        while (e != '0) begin
            if (e[0]) acc = mulmod(acc % op.modulus, pw, op.modulus);
            e = e >> 1;
            pw = mulmod(pw, pw, op.modulus);
        end
        r.result = acc;
        return r;
    endfunction

    function automatic logic [W-1:0] rand_word();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return W'($urandom_range(0, 15));
            3: return '1 - W'($urandom_range(0, 15));
            default: return W'($urandom);
        endcase
    endfunction

    task automatic add_item(logic [W-1:0] b, logic [W-1:0] e, logic [W-1:0] m);
        operands_t op;
        op.base = b;
        op.exponent = e;
        op.modulus = m;
        pending_items.push_back(op);
    endtask

    // driver: takes items from the queue, with a random gap after each
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !s_tready) begin
            // hold the item until accepted
        end else if (send_gap > 0) begin
            s_tvalid <= 1'b0;
            send_gap <= send_gap - 1;
        end else if (pending_items.size() > 0 && !hold_sender) begin
            operands_t op;
            op = pending_items.pop_front();
            s_tvalid <= 1'b1;
            s_tdata <= IN_BYTES_W'(op);
            expected_powers.push_back(predict_power(op));
            send_gap <= $urandom_range(0, 5);
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // monitor and sink: random stalls on the result side, every result checked
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                power_t exp_p;
                if (expected_powers.size() == 0) begin
                    $display("%0t: unexpected result %h error %b", $time, m_tdata, m_tuser);
                    errors++;
                end else begin
                    exp_p = expected_powers.pop_front();
                    if (m_tdata[W-1:0] !== exp_p.result)
                        $display("%0t: result expected %h actual %h", $time,
                                 exp_p.result, m_tdata[W-1:0]);
                    if (m_tuser !== exp_p.error)
                        $display("%0t: error flag expected %b actual %b", $time,
                                 exp_p.error, m_tuser);
                    if (m_tdata[W-1:0] !== exp_p.result || m_tuser !== exp_p.error)
                        errors++;
                end
                recv_gap <= $urandom_range(0, 5);
                m_tready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        // directed corners: zero modulus, zero exponent, modulus one, extremes
        add_item(32'd5, 32'd3, '0);
        add_item('1, '1, '0);
        add_item(32'd7, '0, 32'd1);
        add_item('0, '0, 32'd13);
        add_item('0, 32'd5, 32'd13);
        add_item(32'd9, 32'd1, 32'd1);
        add_item('1, '1, '1);
        add_item('1, 32'd2, '1);
        add_item('1 - 1, '1, '1);
        add_item(32'd100, 32'd7, 32'd13);
        add_item(32'd2, 32'd10, 32'd1000);
        add_item(32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFB);
        add_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0001);
        add_item(32'd3, 32'hAAAA_AAAA, 32'h5555_5555);
        add_item(32'h1234_5678, 32'h5555_5555, 32'hAAAA_AAAB);
        add_item(32'd2, 32'd31, '1);
        for (int i = 0; i < 140; i++)
            add_item(rand_word(), rand_word(), rand_word());
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        // let the sender drain everything out before the second half
        wait (pending_items.size() == 0);
        @(posedge aclk);
        hold_sender <= 1'b1;
        wait (expected_powers.size() == 0);
        @(posedge aclk);
        for (int i = 0; i < 140; i++)
            add_item(rand_word(), rand_word(), rand_word());
        hold_sender <= 1'b0;
        wait (pending_items.size() == 0);
        wait (expected_powers.size() == 0);
        repeat (20) @(posedge aclk);
        if (errors == 0 && expected_powers.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
